[hw/rtl/lcpm_pkg.sv]
// Shared constants, types and helpers for the LED cube PWM multiplexer.
package lcpm_pkg;

    // Cube geometry and PWM depth
    localparam int LAYERS         = 4;
    localparam int LEDS_PER_LAYER = 16;
    localparam int PWM_STEPS      = 16;

    // Field widths fixed by the item format
    localparam int KIND_W   = 1;
    localparam int LAYER_W  = 2;
    localparam int LED_W    = 4;
    localparam int BRIGHT_W = 5;
    localparam int BYTE_W   = 8;

    localparam int LAYER_SLOTS = 1 << LAYER_W;
    localparam int LED_SLOTS   = 1 << LED_W;

    localparam int PHASE_W = (PWM_STEPS > 1) ? $clog2(PWM_STEPS) : 1;
    localparam int CMP_W   = (PHASE_W > BRIGHT_W) ? PHASE_W : BRIGHT_W;

    localparam int IN_FIELDS_W  = LAYER_W + LED_W + BRIGHT_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W  = 3 * BYTE_W;

    // Range limits, one bit wider than the index they bound
    localparam logic [LAYER_W:0] LAYER_LIMIT = (LAYER_W + 1)'(LAYERS);
    localparam logic [LED_W:0]   LED_LIMIT   = (LED_W + 1)'(LEDS_PER_LAYER);

    localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(PWM_STEPS - 1);
    localparam logic [LAYER_W-1:0] LAYER_LAST = LAYER_W'(LAYERS - 1);

    localparam logic [BYTE_W-1:0] ALL_ONES       = 8'hff;
    localparam logic [BYTE_W-1:0] LAYER_BIT_BASE = 8'h10;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK  = 1'b0,
        KIND_WRITE = 1'b1
    } t_kind;

    typedef logic [LAYER_W-1:0]  t_layer;
    typedef logic [LED_W-1:0]    t_led;
    typedef logic [BRIGHT_W-1:0] t_bright;
    typedef logic [PHASE_W-1:0]  t_phase;

    // Active-low layer select with the low nibble held high
    function automatic logic [BYTE_W-1:0] layer_drive_byte(input t_layer layer);
        return ALL_ONES & ~(LAYER_BIT_BASE << layer);
    endfunction

endpackage

[hw/rtl/lcpm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module lcpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  logic [WIDTH-1:0]           i_wdata,
    input  logic                       i_re,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic [WIDTH-1:0]           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/led_cube_pwm_multiplexer.sv]
// Top level of the LED cube PWM multiplexer: brightness banks, PWM sequencing, output word.
//
// Takes one word per clock, tick or brightness write alike, and keeps that rate while the
// output side accepts. A write stores one LED's brightness and gives no output word; a tick
// advances the PWM phase (and the layer when the phase wraps) and gives one output word
// via the read and output registers. Brightness lives in one small RAM per LED position,
// addressed by layer, so a tick reads the whole active layer in a single registered read
// and compares all positions in parallel. Per-entry valid flags clear the store at reset,
// so no clearing pass is needed and the block is ready from the first cycle after reset.
// A write is committed to RAM at the edge it is taken, before any later tick reads.
module led_cube_pwm_multiplexer (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // layer_index [1:0], led_index [5:2], brightness [10:6], zero [15:11]
    input  logic [lcpm_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    // kind [0]
    input  logic [lcpm_pkg::KIND_W-1:0]        i_s_axis_tuser,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // layer_drive [7:0], columns_high [15:8], columns_low [23:16]
    output logic [lcpm_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata
);

    import lcpm_pkg::*;

    t_kind   w_kind;
    t_layer  w_layer_idx;
    t_led    w_led_idx;
    t_bright w_bright;

    logic w_adv;
    logic w_accept;
    logic w_tick;
    logic w_write;

    t_phase r_phase;
    t_phase n_phase;
    t_layer r_layer;
    t_layer n_layer;
    logic   w_phase_wrap;

    logic [LEDS_PER_LAYER-1:0] r_valid [LAYER_SLOTS];

    // Read stage: RAM data sits in the RAM output registers
    logic                      r_s1_vld;
    t_phase                    r_s1_phase;
    t_layer                    r_s1_layer;
    logic [LEDS_PER_LAYER-1:0] r_s1_vmask;

    t_bright             w_rdata [LEDS_PER_LAYER];
    logic [LED_SLOTS-1:0] w_cols;

    logic                   r_out_vld;
    logic [OUT_TDATA_W-1:0] r_out_data;

    assign w_kind      = t_kind'(i_s_axis_tuser);
    assign w_layer_idx = i_s_axis_tdata[LAYER_W-1:0];
    assign w_led_idx   = i_s_axis_tdata[LAYER_W +: LED_W];
    assign w_bright    = i_s_axis_tdata[LAYER_W + LED_W +: BRIGHT_W];

    assign w_adv           = !r_out_vld || i_m_axis_tready;
    assign o_s_axis_tready = !r_s1_vld || w_adv;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_tick          = w_accept && (w_kind == KIND_TICK);
    // drop writes aimed beyond the cube
    assign w_write         = w_accept && (w_kind == KIND_WRITE)
                             && ({1'b0, w_layer_idx} < LAYER_LIMIT)
                             && ({1'b0, w_led_idx} < LED_LIMIT);

    // Advance phase first; layer steps on phase wrap
    always_comb begin
        w_phase_wrap = (r_phase == PHASE_LAST);
        n_phase      = w_phase_wrap ? '0 : r_phase + 1'b1;
        n_layer      = r_layer;
        if (w_phase_wrap) begin
            n_layer = (r_layer == LAYER_LAST) ? '0 : r_layer + 1'b1;
        end
    end

    for (genvar g = 0; g < LEDS_PER_LAYER; g++) begin : g_bank
        lcpm_ram #(
            .WIDTH (BRIGHT_W),
            .DEPTH (LAYER_SLOTS)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (w_write && (w_led_idx == LED_W'(g))),
            .i_waddr (w_layer_idx),
            .i_wdata (w_bright),
            .i_re    (w_tick),
            .i_raddr (n_layer),
            .o_rdata (w_rdata[g])
        );
    end

    for (genvar g = 0; g < LED_SLOTS; g++) begin : g_col
        if (g < LEDS_PER_LAYER) begin : g_live
            assign w_cols[g] = r_s1_vmask[g]
                               && (CMP_W'(w_rdata[g]) > CMP_W'(r_s1_phase));
        end else begin : g_absent
            assign w_cols[g] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_layer <= '0;
            for (int l = 0; l < LAYER_SLOTS; l++) begin
                r_valid[l] <= '0;
            end
        end else begin
            if (w_tick) begin
                r_phase <= n_phase;
                r_layer <= n_layer;
            end
            if (w_write) begin
                r_valid[w_layer_idx][w_led_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_tick) begin
                r_s1_vld <= 1'b1;
            end else if (w_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (w_adv) begin
                r_out_vld <= r_s1_vld;
            end
        end
    end

    // Hold the read-stage payload while stalled; RAM output holds since no read is issued
    always_ff @(posedge i_clk) begin
        if (w_tick) begin
            r_s1_phase <= n_phase;
            r_s1_layer <= n_layer;
            r_s1_vmask <= r_valid[n_layer];
        end
        if (w_adv && r_s1_vld) begin
            r_out_data <= {w_cols[BYTE_W-1:0],
                           w_cols[LED_SLOTS-1:BYTE_W],
                           layer_drive_byte(r_s1_layer)};
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;

endmodule
